// ----- src/roc_readback_frame_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the readback frame decoder modules.
// ----------------------------------------------------------------------------
`ifndef ROC_READBACK_FRAME_DECODER_TOP_ASSERT_SVH
`define ROC_READBACK_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ROCRFD_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rocrfd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ROCRFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rocrfd: next-cycle check failed");

`endif

// ----- src/rocrfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rocrfd_pkg
// Types and constants shared by the readback frame decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rocrfd_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CHANNEL_NUMBER  = 2'd0;
   localparam logic [1:0] CSR_NUM_ROCS        = 2'd1;
   localparam logic [1:0] CSR_WANTED_REGISTER = 2'd2;

   localparam logic [5:0] CHANNEL_RESET  = 6'd0;
   localparam logic [4:0] NUM_ROCS_RESET = 5'd8;
   localparam logic [3:0] WANTED_RESET   = 4'd12;

   // Marker value that never names a chip.
   localparam logic [4:0] MARKER_SKIP = 5'h1e;

   localparam logic [15:0] COUNT_MAX = 16'hffff;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_DATA,
      CMD_MARK
   } cmd_kind_type;

   // One classified word travelling from the front end to the back end.
   typedef struct packed {
      cmd_kind_type kind;
      logic [4:0]   roc_num;
      logic         data_bit;
      logic [3:0]   expected_id;
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/rocrfd_if.sv -----
// ----------------------------------------------------------------------------
// rocrfd_req_if / rocrfd_rsp_if
// Valid/ready channels for readout words in and decoded frames out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rocrfd_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] fifo_word;
   logic [3:0]  expected_id;

   modport source (output valid, output operation, output fifo_word,
                   output expected_id, input ready);
   modport sink   (input valid, input operation, input fifo_word,
                   input expected_id, output ready);
endinterface

interface rocrfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  roc_index;
   logic [15:0] frame_payload;
   logic [3:0]  decoded_id;
   logic [3:0]  decoded_register;
   logic        length_ok;
   logic        frame_good;
   logic [15:0] frames_seen;
   logic [15:0] good_frames;

   modport source (output valid, output roc_index, output frame_payload,
                   output decoded_id, output decoded_register, output length_ok,
                   output frame_good, output frames_seen, output good_frames,
                   input ready);
   modport sink   (input valid, input roc_index, input frame_payload,
                   input decoded_id, input decoded_register, input length_ok,
                   input frame_good, input frames_seen, input good_frames,
                   output ready);
endinterface

`default_nettype wire

// ----- src/rocrfd_front.sv -----
// ----------------------------------------------------------------------------
// rocrfd_front
// Accepts readout words, filters them and classifies the survivors.
// ----------------------------------------------------------------------------
`default_nettype none

module rocrfd_front
   import rocrfd_pkg::*;
#(
   parameter int MAX_ROCS = 16
) (
   rocrfd_req_if.sink req_chan,
   input  wire logic [5:0] channel_number,
   input  wire logic [4:0] num_rocs,
   output logic            push_valid,
   output cmd_type         push_cmd,
   input  wire logic       push_ready
);

   logic [5:0]  chan;
   logic [4:0]  marker;
   logic [12:0] addr;
   logic [7:0]  hdr;
   logic        keep;

   assign chan   = req_chan.fifo_word[31:26];
   assign marker = req_chan.fifo_word[25:21];
   assign addr   = req_chan.fifo_word[20:8];
   assign hdr    = req_chan.fifo_word[7:0];

   // Clears always pass; words need channel, zero address, chip in range.
   always_comb begin
      keep = req_chan.operation ||
             ((chan == channel_number) && (addr == 13'd0) && (marker != MARKER_SKIP) &&
              (marker != 5'd0) && (marker <= num_rocs) && (marker <= 5'(MAX_ROCS)));
   end

   always_comb begin
      push_cmd.roc_num     = marker;
      push_cmd.data_bit    = hdr[0];
      push_cmd.expected_id = req_chan.expected_id;
      priority if (req_chan.operation) begin
         push_cmd.kind = CMD_CLEAR;
      end else if (hdr[1]) begin
         push_cmd.kind = CMD_MARK;
      end else begin
         push_cmd.kind = CMD_DATA;
      end
   end

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid && keep;

endmodule

`default_nettype wire

// ----- src/rocrfd_queue.sv -----
// ----------------------------------------------------------------------------
// rocrfd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rocrfd_queue
   import rocrfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  cmd_type      push_cmd,
   output logic         push_ready,
   output logic         pop_valid,
   output cmd_type      pop_cmd,
   input  wire logic    pop_ready
);

`include "roc_readback_frame_decoder_top_assert.svh"

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ROCRFD_ASSERT_NEXT(a_queue_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)

endmodule

`default_nettype wire

// ----- src/rocrfd_back.sv -----
// ----------------------------------------------------------------------------
// rocrfd_back
// Per-chip frame assembly, counters and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rocrfd_back
   import rocrfd_pkg::*;
#(
   parameter int MAX_ROCS   = 16,
   parameter int FRAME_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_ready,
   input  wire logic [3:0] wanted_register,
   rocrfd_rsp_if.source rsp_chan
);

`include "roc_readback_frame_decoder_top_assert.svh"

   localparam int IDX_W = (MAX_ROCS > 1) ? $clog2(MAX_ROCS) : 1;
   localparam int CNT_W = $clog2(FRAME_BITS + 2);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FRAME_BITS + 1);

   logic                  started_ff [MAX_ROCS];
   logic [CNT_W-1:0]      count_ff   [MAX_ROCS];
   logic [FRAME_BITS-1:0] shift_ff   [MAX_ROCS];
   logic [15:0]           ftotal_ff  [MAX_ROCS];
   logic [15:0]           gtotal_ff  [MAX_ROCS];

   logic                  started_in;
   logic [CNT_W-1:0]      count_in;
   logic [FRAME_BITS-1:0] shift_in;
   logic [15:0]           ftotal_in;
   logic [15:0]           gtotal_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            roc_index_ff;
   logic [15:0]           payload_ff, payload_in;
   logic [3:0]            id_ff, id_in;
   logic [3:0]            reg_id_ff, reg_id_in;
   logic                  len_ok_ff, len_ok_in;
   logic                  good_ff, good_in;
   logic [15:0]           fseen_ff, gseen_ff;

   logic [IDX_W-1:0]      idx;
   logic [4:0]            roc_off;
   logic                  pop, emit, out_free;
   logic [CNT_W-1:0]      count_tb;
   logic [FRAME_BITS-1:0] shift_tb;
   logic [FRAME_BITS+15:0] shift_ext;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign cmd_ready = out_free;
   assign pop       = cmd_valid && out_free;
   assign roc_off   = cmd.roc_num - 5'd1;
   assign idx       = roc_off[IDX_W-1:0];

   // One data bit into the open frame of the addressed chip.
   always_comb begin
      count_tb = (count_ff[idx] < CNT_OVER) ? count_ff[idx] + CNT_W'(1) : count_ff[idx];
      if (count_ff[idx] < CNT_FULL) begin
         shift_tb = {shift_ff[idx][FRAME_BITS-2:0], cmd.data_bit};
      end else begin
         shift_tb = shift_ff[idx];
      end
      shift_ext = {shift_tb, 16'd0};
   end

   always_comb begin
      len_ok_in = (count_tb == CNT_FULL);
      if (len_ok_in) begin
         payload_in = shift_ext[FRAME_BITS+15 -: 16];
         id_in      = shift_tb[FRAME_BITS-1 -: 4];
         reg_id_in  = shift_tb[FRAME_BITS-5 -: 4];
      end else begin
         payload_in = 16'd0;
         id_in      = 4'd0;
         reg_id_in  = 4'd0;
      end
      good_in = len_ok_in && (id_in == cmd.expected_id) && (reg_id_in == wanted_register);
   end

   always_comb begin
      started_in = started_ff[idx];
      count_in   = count_ff[idx];
      shift_in   = shift_ff[idx];
      ftotal_in  = ftotal_ff[idx];
      gtotal_in  = gtotal_ff[idx];
      emit       = 1'b0;
      unique case (cmd.kind)
         CMD_DATA: begin
            if (started_ff[idx]) begin
               count_in = count_tb;
               shift_in = shift_tb;
            end
         end
         CMD_MARK: begin
            started_in = 1'b1;
            count_in   = '0;
            shift_in   = '0;
            if (started_ff[idx]) begin
               emit = 1'b1;
               if (ftotal_ff[idx] != COUNT_MAX) begin
                  ftotal_in = ftotal_ff[idx] + 16'd1;
               end
               if (good_in && (gtotal_ff[idx] != COUNT_MAX)) begin
                  gtotal_in = gtotal_ff[idx] + 16'd1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = out_free ? (pop && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && (cmd.kind == CMD_CLEAR))) begin
         for (int r = 0; r < MAX_ROCS; r++) begin
            started_ff[r] <= 1'b0;
            count_ff[r]   <= '0;
            shift_ff[r]   <= '0;
            ftotal_ff[r]  <= '0;
            gtotal_ff[r]  <= '0;
         end
      end else if (pop) begin
         started_ff[idx] <= started_in;
         count_ff[idx]   <= count_in;
         shift_ff[idx]   <= shift_in;
         ftotal_ff[idx]  <= ftotal_in;
         gtotal_ff[idx]  <= gtotal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         roc_index_ff <= cmd.roc_num;
         payload_ff   <= payload_in;
         id_ff        <= id_in;
         reg_id_ff    <= reg_id_in;
         len_ok_ff    <= len_ok_in;
         good_ff      <= good_in;
         fseen_ff     <= ftotal_in;
         gseen_ff     <= gtotal_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.roc_index        = roc_index_ff;
   assign rsp_chan.frame_payload    = payload_ff;
   assign rsp_chan.decoded_id       = id_ff;
   assign rsp_chan.decoded_register = reg_id_ff;
   assign rsp_chan.length_ok        = len_ok_ff;
   assign rsp_chan.frame_good       = good_ff;
   assign rsp_chan.frames_seen      = fseen_ff;
   assign rsp_chan.good_frames      = gseen_ff;

   `ROCRFD_ASSERT_IMPLIES(a_good_needs_len, clock, reset, rsp_valid_ff && good_ff, len_ok_ff)
   `ROCRFD_ASSERT_IMPLIES(a_bad_len_zero, clock, reset, rsp_valid_ff && !len_ok_ff, (payload_ff == 16'd0) && (id_ff == 4'd0) && (reg_id_ff == 4'd0))
   `ROCRFD_ASSERT_IMPLIES(a_good_le_seen, clock, reset, rsp_valid_ff, (gseen_ff <= fseen_ff) && (fseen_ff != 16'd0))

endmodule

`default_nettype wire

// ----- src/roc_readback_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// roc_readback_frame_decoder_top
// Throughput: one readout word per cycle while the result channel is not
// stalled, set by the per-chip read-modify-write in the back end. A closing
// marker passes through the command queue and then the result register.
// Reset (synchronous, active high) clears the registers to their defaults,
// all per-chip frame state and counts, the command queue and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure: the front end filters and classifies each transfer on the
// request channel, a two-entry queue decouples it from the back end, and the
// back end keeps the per-chip frame state and drives a registered result
// stage. The back end takes a new command whenever the result register is
// empty or being drained, so a result blocks the next word only while stalled.
module roc_readback_frame_decoder_top
   import rocrfd_pkg::*;
#(
   parameter int MAX_ROCS   = 16,
   parameter int FRAME_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rocrfd_req_if.sink      req_chan,
   rocrfd_rsp_if.source    rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [5:0] csr_wdata
);

   // Configuration registers. Writes are to be made only while the block is idle;
   // the block does not enforce it. Both ends use the live values without snapshotting.
   logic [5:0] channel_ff;
   logic [4:0] num_rocs_ff;
   logic [3:0] wanted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff  <= CHANNEL_RESET;
         num_rocs_ff <= NUM_ROCS_RESET;
         wanted_ff   <= WANTED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_NUMBER:  channel_ff  <= csr_wdata;
            CSR_NUM_ROCS:        num_rocs_ff <= csr_wdata[4:0];
            CSR_WANTED_REGISTER: wanted_ff   <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Classified commands between the front end and the queue.
   logic    push_valid, push_ready;
   cmd_type push_cmd;

   // Commands between the queue and the back end.
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   rocrfd_front #(
      .MAX_ROCS (MAX_ROCS)
   ) u_front (
      .req_chan       (req_chan),
      .channel_number (channel_ff),
      .num_rocs       (num_rocs_ff),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd),
      .push_ready     (push_ready)
   );

   rocrfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   rocrfd_back #(
      .MAX_ROCS   (MAX_ROCS),
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (pop_valid),
      .cmd             (pop_cmd),
      .cmd_ready       (pop_ready),
      .wanted_register (wanted_ff),
      .rsp_chan        (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for roc_readback_frame_decoder_top. Readout words are
// sent on the request channel. A model of the per-chip frame state held in
// the bench works out each decoded frame. Every transfer on the result
// channel is checked against the oldest outstanding frame. Random idling and
// several register settings are applied in turn.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rocrfd_pkg::*;

   localparam int MAX_ROCS    = 16;
   localparam int FRAME_BITS  = 16;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_GAP  = 8;

   // Request operation codes.
   localparam logic OP_WORD  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // One decoded frame as it leaves the block.
   typedef struct packed {
      logic [4:0]  roc_index;
      logic [15:0] payload;
      logic [3:0]  id;
      logic [3:0]  reg_id;
      logic        len_ok;
      logic        good;
      logic [15:0] frames;
      logic [15:0] goods;
   } frame_rec_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [5:0] csr_wdata;

   rocrfd_req_if req_chan ();
   rocrfd_rsp_if rsp_chan ();

   roc_readback_frame_decoder_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Model of the decoder: register copies and the per-chip frame state,
   // indexed by chip number (1-based, as carried in the word).
   // ------------------------------------------------------------------------
   logic [5:0]  cfg_channel;
   logic [4:0]  cfg_num_rocs;
   logic [3:0]  cfg_wanted;

   logic        roc_open   [1:MAX_ROCS];
   logic [4:0]  roc_nbits  [1:MAX_ROCS];
   logic [15:0] roc_bits   [1:MAX_ROCS];
   logic [15:0] roc_frames [1:MAX_ROCS];
   logic [15:0] roc_goods  [1:MAX_ROCS];

   // Frames the block owes us, oldest first.
   frame_rec_type frames_due [$];
   int unsigned   mismatches;

   // Idling odds: one chance in N per item or cycle of starting a burst;
   // zero means that side never idles.
   int unsigned gap_odds;
   int unsigned stall_odds;

   // Stimulus plan per chip: target frame length, bits already sent and the
   // frame content, first bit in the MSB.
   int          plan_len     [1:MAX_ROCS];
   int          plan_pos     [1:MAX_ROCS];
   logic [15:0] plan_payload [1:MAX_ROCS];

   function automatic void clear_chips();
      for (int r = 1; r <= MAX_ROCS; r++) begin
         roc_open[r]   = 1'b0;
         roc_nbits[r]  = '0;
         roc_bits[r]   = '0;
         roc_frames[r] = '0;
         roc_goods[r]  = '0;
      end
   endfunction

   // A data bit is shifted in until the frame is full; the count keeps going
   // one step further so that an over-long frame is still recognised.
   function automatic void shift_in(input int r, input logic b);
      if (roc_nbits[r] < FRAME_BITS)
         roc_bits[r] = {roc_bits[r][14:0], b};
      if (roc_nbits[r] < FRAME_BITS + 1)
         roc_nbits[r] = roc_nbits[r] + 5'd1;
   endfunction

   // Applies one accepted request to the model. Returns 1 with the frame
   // filled in when the word closes a frame.
   function automatic bit decode_word(input logic op, input logic [31:0] word,
                                      input logic [3:0] exp_id,
                                      output frame_rec_type rec);
      logic [4:0] mk;
      logic       len_ok;
      rec = '0;
      if (op == OP_CLEAR) begin
         clear_chips();
         return 0;
      end
      mk = word[25:21];
      if (word[31:26] != cfg_channel || word[20:8] != '0 || mk == MARKER_SKIP)
         return 0;
      if (mk == '0 || mk > cfg_num_rocs || mk > MAX_ROCS)
         return 0;
      if (!word[1]) begin
         if (roc_open[mk])
            shift_in(mk, word[0]);
         return 0;
      end
      if (!roc_open[mk]) begin
         roc_open[mk]  = 1'b1;
         roc_nbits[mk] = '0;
         roc_bits[mk]  = '0;
         return 0;
      end
      // The closing marker carries the last bit of the frame and also opens
      // the next one.
      shift_in(mk, word[0]);
      len_ok = (roc_nbits[mk] == FRAME_BITS);
      rec.roc_index = mk;
      rec.len_ok    = len_ok;
      if (len_ok) begin
         rec.payload = roc_bits[mk];
         rec.id      = roc_bits[mk][15:12];
         rec.reg_id  = roc_bits[mk][11:8];
      end
      rec.good = len_ok && rec.id == exp_id && rec.reg_id == cfg_wanted;
      if (roc_frames[mk] != COUNT_MAX)
         roc_frames[mk] = roc_frames[mk] + 16'd1;
      if (rec.good && roc_goods[mk] != COUNT_MAX)
         roc_goods[mk] = roc_goods[mk] + 16'd1;
      rec.frames    = roc_frames[mk];
      rec.goods     = roc_goods[mk];
      roc_nbits[mk] = '0;
      roc_bits[mk]  = '0;
      return 1;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
   endfunction

   function automatic string show_frame(input frame_rec_type f);
      return $sformatf("roc %0d payload %h id %h reg %h len_ok %b good %b frames %0d good %0d",
                       f.roc_index, f.payload, f.id, f.reg_id, f.len_ok, f.good,
                       f.frames, f.goods);
   endfunction

   // Every transfer on the result channel is compared with the oldest frame
   // still owed, field by field.
   always @(posedge clock) begin : check_frames
      frame_rec_type got;
      frame_rec_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.roc_index = rsp_chan.roc_index;
         got.payload   = rsp_chan.frame_payload;
         got.id        = rsp_chan.decoded_id;
         got.reg_id    = rsp_chan.decoded_register;
         got.len_ok    = rsp_chan.length_ok;
         got.good      = rsp_chan.frame_good;
         got.frames    = rsp_chan.frames_seen;
         got.goods     = rsp_chan.good_frames;
         if (frames_due.size() == 0) begin
            note_mismatch({"frame with none outstanding: ", show_frame(got)});
         end else begin
            want = frames_due.pop_front();
            if (got.roc_index !== want.roc_index || got.payload !== want.payload ||
                got.id !== want.id || got.reg_id !== want.reg_id ||
                got.len_ok !== want.len_ok || got.good !== want.good ||
                got.frames !== want.frames || got.goods !== want.goods)
               note_mismatch({"expected ", show_frame(want), "\n   actual   ",
                              show_frame(got)});
         end
      end
   end

   // The receiving side stalls in random bursts.
   initial begin : result_sink
      int stall_left;
      stall_left      = 0;
      rsp_chan.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0)
            stall_left--;
         else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0)
            stall_left = $urandom_range(16, 1);
         rsp_chan.ready <= (stall_left == 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Presents one request and waits for its transfer. Inputs change on the
   // falling edge; the handshake is sampled on the rising edge.
   task automatic send_word(input logic op, input logic [31:0] word,
                            input logic [3:0] exp_id);
      frame_rec_type rec;
      @(negedge clock);
      if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(16, 1)) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.fifo_word   <= word;
      req_chan.expected_id <= exp_id;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (decode_word(op, word, exp_id, rec))
         frames_due.insert(frames_due.size(), rec);
   endtask

   // Builds a readout word; the unused header bits are always random.
   function automatic logic [31:0] pack_word(input logic [5:0] chan,
                                             input logic [4:0] mk,
                                             input logic [12:0] addr,
                                             input logic mark, input logic dbit);
      return {chan, mk, addr, 6'($urandom), mark, dbit};
   endfunction

   // Stops sending, waits until every owed frame has been transferred, then
   // lets the pipeline run empty, since words that close no frame may still
   // be in flight.
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   // Writes all three registers, one per cycle. The narrower registers take
   // only the low bits of the write data.
   task automatic set_config(input logic [5:0] chan, input logic [5:0] rocs,
                             input logic [5:0] wanted);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CHANNEL_NUMBER;
      csr_wdata <= chan;
      @(negedge clock);
      csr_index <= CSR_NUM_ROCS;
      csr_wdata <= rocs;
      @(negedge clock);
      csr_index <= CSR_WANTED_REGISTER;
      csr_wdata <= wanted;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_channel  = chan;
      cfg_num_rocs = rocs[4:0];
      cfg_wanted   = wanted[3:0];
   endtask

   // Chooses the next frame for a chip: mostly the proper length with the
   // wanted register id, sometimes short or over-long.
   function automatic void plan_frame(input int r);
      plan_pos[r]     = 0;
      plan_len[r]     = ($urandom_range(3, 0) == 0) ? $urandom_range(20, 1) : FRAME_BITS;
      plan_payload[r] = {4'($urandom),
                         ($urandom_range(3, 0) == 0) ? 4'($urandom) : cfg_wanted,
                         8'($urandom)};
   endfunction

   // One random request. Most are frame words, interleaved
   // across the chips; the rest are clears and words the block must drop.
   task automatic send_random_item();
      int          pick;
      int          r;
      logic [31:0] word;
      logic [3:0]  exp_id;
      logic        dbit;
      pick   = $urandom_range(99, 0);
      exp_id = 4'($urandom);
      if (pick < 2) begin
         send_word(OP_CLEAR, $urandom, exp_id);
      end else if (pick < 10) begin
         word = pack_word(cfg_channel, 5'($urandom_range(cfg_num_rocs, 1)), '0,
                          1'($urandom), 1'($urandom));
         case (pick % 5)
            0: word[31:26] = cfg_channel ^ 6'($urandom_range(63, 1));
            1: word[20:8]  = 13'($urandom_range(8191, 1));
            2: word[25:21] = MARKER_SKIP;
            3: word[25:21] = '0;
            default: word[25:21] = 5'($urandom_range(31, cfg_num_rocs + 1));
         endcase
         send_word(OP_WORD, word, exp_id);
      end else begin
         r    = $urandom_range(cfg_num_rocs, 1);
         dbit = plan_payload[r][15 - (plan_pos[r] % 16)];
         if (plan_pos[r] + 1 < plan_len[r]) begin
            plan_pos[r]++;
            send_word(OP_WORD, pack_word(cfg_channel, r[4:0], '0, 1'b0, dbit), exp_id);
         end else begin
            // Closing marker: the expected id usually matches the frame.
            if ($urandom_range(3, 0) != 0)
               exp_id = plan_payload[r][15:12];
            plan_frame(r);
            send_word(OP_WORD, pack_word(cfg_channel, r[4:0], '0, 1'b1, dbit), exp_id);
         end
      end
   endtask

   // One setting of the registers followed by a stretch of random traffic.
   task automatic run_phase(input logic [5:0] chan, input logic [5:0] rocs,
                            input logic [5:0] wanted, input int items,
                            input int unsigned send_gaps, input int unsigned sink_stalls);
      settle();
      set_config(chan, rocs, wanted);
      gap_odds   = send_gaps;
      stall_odds = sink_stalls;
      for (int r = 1; r <= MAX_ROCS; r++)
         plan_frame(r);
      repeat (items) send_random_item();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Registers at their reset values: a data bit before any marker is
   // ignored, the first marker opens a frame, a proper frame with the wanted
   // register and matching id is good, and a marker straight after closes a
   // one-bit frame.
   task automatic test_default_registers();
      logic [15:0] content;
      content = 16'h5CA3;
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b0, 1'b1), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b1, 1'b1), 4'd0);
      for (int k = 15; k >= 1; k--)
         send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b0, content[k]), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b1, content[0]), 4'd5);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b1, 1'b0), 4'd5);
   endtask

   // Markers the block must drop (wrong channel, address or chip), then a
   // proper marker, then a clear after which the next marker only opens.
   task automatic test_rejected_words();
      send_word(OP_WORD, pack_word(6'd1, 5'd1, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, 13'h1fff, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, MARKER_SKIP, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd0, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, NUM_ROCS_RESET + 5'd1, '0, 1'b1, 1'b0),
                4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b1, 1'b1), 4'd0);
      send_word(OP_CLEAR, 32'hffff_ffff, 4'hf);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b1, 1'b1), 4'd0);
      send_word(OP_WORD, pack_word(CHANNEL_RESET, 5'd1, '0, 1'b1, 1'b1), 4'd0);
   endtask

   // Extremes of the chip range: num_rocs beyond the chip count still drops
   // chips above sixteen, zero chips drops everything, one chip drops chip 2.
   task automatic test_chip_range();
      settle();
      set_config(6'd63, 6'h3f, 6'h30);
      send_word(OP_WORD, pack_word(6'd63, 5'd16, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(6'd63, 5'd16, '0, 1'b1, 1'b1), 4'd0);
      send_word(OP_WORD, pack_word(6'd63, 5'd17, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(6'd63, 5'd31, '0, 1'b1, 1'b0), 4'd0);
      settle();
      set_config(6'd0, 6'd0, 6'd15);
      send_word(OP_WORD, pack_word(6'd0, 5'd1, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(6'd0, 5'd1, '0, 1'b1, 1'b0), 4'd0);
      settle();
      set_config(6'd42, 6'd1, 6'd3);
      send_word(OP_WORD, pack_word(6'd42, 5'd1, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(6'd42, 5'd1, '0, 1'b1, 1'b1), 4'd0);
      send_word(OP_WORD, pack_word(6'd42, 5'd2, '0, 1'b1, 1'b0), 4'd0);
      send_word(OP_WORD, pack_word(6'd42, 5'd2, '0, 1'b1, 1'b0), 4'd0);
   endtask

   // Random traffic under several settings, the extremes first. Each phase
   // starts only once every owed frame has arrived.
   task automatic test_random_traffic();
      run_phase(6'd63, 6'd16, 6'd15, 320, 6, 6);
      run_phase(6'd0, 6'd1, 6'd0, 320, 4, 10);
      run_phase(6'($urandom), {1'($urandom), 5'($urandom_range(16, 1))}, 6'($urandom),
                320, 0, 5);
      run_phase(6'($urandom), {1'($urandom), 5'($urandom_range(16, 1))}, 6'($urandom),
                320, 5, 0);
      run_phase(6'($urandom), {1'($urandom), 5'($urandom_range(16, 1))}, 6'($urandom),
                320, 3, 3);
   endtask

   // Back-to-back transfers on both sides with no idling at all.
   task automatic test_full_rate();
      run_phase(6'($urandom), 6'($urandom_range(16, 1)), 6'($urandom), 320, 0, 0);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      req_chan.valid       = 1'b0;
      req_chan.operation   = OP_WORD;
      req_chan.fifo_word   = '0;
      req_chan.expected_id = '0;
      csr_we               = 1'b0;
      csr_index            = CSR_CHANNEL_NUMBER;
      csr_wdata            = '0;
      mismatches           = 0;
      gap_odds             = 0;
      stall_odds           = 0;
      cfg_channel          = CHANNEL_RESET;
      cfg_num_rocs         = NUM_ROCS_RESET;
      cfg_wanted           = WANTED_RESET;
      clear_chips();

      // Synchronous reset held from the start and released between edges.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed tests run with moderate idling on both sides.
      gap_odds   = 5;
      stall_odds = 5;
      test_default_registers();
      test_rejected_words();
      test_chip_range();
      test_random_traffic();
      test_full_rate();

      // Wait for the last owed frame and let the pipeline empty.
      settle();
      if (frames_due.size() != 0)
         note_mismatch($sformatf("%0d frames never arrived", frames_due.size()));

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule
